>>> sv/sidtoa_pkg.sv
// Shared constants, types and elaboration-time helpers for the signed
// integer to decimal ASCII core. No dependencies.
`default_nettype none

package sidtoa_pkg;

    localparam int NUMBER_W = 28;          // input field width, two's complement
    localparam int MAG_W    = 28;          // magnitude width, holds 2**27
    localparam int DIGIT_W  = 4;           // one BCD digit
    localparam int CHAR_W   = 6;           // output character field width

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CHAR_MINUS = 6'd45;  // '-'
    localparam t_char CHAR_ZERO  = 6'd48;  // '0'

    // 10**n, evaluated at elaboration only
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] w;
        w = 64'd1;
        for (int i = 0; i < n; i++) begin
            w = w * 64'd10;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/sidtoa_digit_cell.sv
// One cell of the digit chain: extracts the decimal digit of one fixed
// place from the remainder and hands the word on. Depends on sidtoa_pkg.
`default_nettype none

module sidtoa_digit_cell #(
    parameter int DIGIT_PLACES = 8,
    parameter int PLACE        = 0       // 0 is the most significant place
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // upstream: remainder, sign, digits so far
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic [sidtoa_pkg::MAG_W+DIGIT_PLACES*sidtoa_pkg::DIGIT_W:0] i_word,
    // downstream
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic [sidtoa_pkg::MAG_W+DIGIT_PLACES*sidtoa_pkg::DIGIT_W:0] o_word
);
    import sidtoa_pkg::*;

    localparam int          WORD_W = MAG_W + DIGIT_PLACES * DIGIT_W + 1;
    localparam logic [63:0] WEIGHT = pow10(DIGIT_PLACES - 1 - PLACE);

    logic                r_valid;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   n_word;
    logic [MAG_W-1:0]    rem_in;
    logic [DIGIT_W-1:0]  digit;
    logic [MAG_W-1:0]    sub;
    logic                load;

    assign rem_in  = i_word[MAG_W-1:0];
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // nine parallel compares against the multiples of this place's weight
    always_comb begin
        digit = '0;
        sub   = '0;
        for (int d = 1; d < 10; d++) begin
            if ({{(64-MAG_W){1'b0}}, rem_in} >= 64'(d) * WEIGHT) begin
                digit = DIGIT_W'(d);
                sub   = MAG_W'(64'(d) * WEIGHT);
            end
        end
        n_word                                    = i_word;
        n_word[MAG_W-1:0]                         = rem_in - sub;
        n_word[MAG_W+1+PLACE*DIGIT_W +: DIGIT_W]  = digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> sv/sidtoa_serializer.sv
// Turns one finished sign/digit word into a run of ASCII beats, dropping
// leading zeros. Depends on sidtoa_pkg.
`default_nettype none

module sidtoa_serializer #(
    parameter int DIGIT_PLACES = 8
) (
    input  wire logic                                               i_clk,
    input  wire logic                                               i_rst_n,
    input  wire logic                                               i_valid,
    output logic                                                    o_ready,
    input  wire logic                                               i_sign,
    input  wire logic [DIGIT_PLACES*sidtoa_pkg::DIGIT_W-1:0]        i_digits,
    output logic                                                    o_valid,
    input  wire logic                                               i_ready,
    output sidtoa_pkg::t_char                                       o_char,
    output logic                                                    o_last
);
    import sidtoa_pkg::*;

    localparam int IDX_W = (DIGIT_PLACES > 1) ? $clog2(DIGIT_PLACES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_PLACES - 1);

    logic                              r_valid;
    logic                              r_minus;
    logic [IDX_W-1:0]                  r_idx;
    logic [DIGIT_PLACES*DIGIT_W-1:0]   r_digits;
    logic [IDX_W-1:0]                  start_idx;
    logic [DIGIT_W-1:0]                cur_digit;
    logic                              take;

    // first nonzero place; an all-zero word starts on the units place
    always_comb begin
        start_idx = LAST_IDX;
        for (int i = DIGIT_PLACES - 1; i >= 0; i--) begin
            if (i_digits[i*DIGIT_W +: DIGIT_W] != '0) begin
                start_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = r_digits[r_idx*DIGIT_W +: DIGIT_W];
    assign o_last    = !r_minus && (r_idx == LAST_IDX);
    assign o_char    = r_minus ? CHAR_MINUS : CHAR_ZERO + t_char'(cur_digit);
    assign o_valid   = r_valid;
    assign take      = r_valid && i_ready;
    assign o_ready   = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_minus  <= i_sign;
            r_idx    <= start_idx;
            r_digits <= i_digits;
        end else if (take) begin
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII core: front stage,
// digit cell chain and serializer. Depends on sidtoa_pkg, sidtoa_digit_cell,
// sidtoa_serializer.
//
//  channel  | dir | tdata bits (low up)           | tuser | tlast
//  ---------+-----+-------------------------------+-------+----------------------
//  s_axis   | in  | number[27:0] signed, 4'b0 pad | -     | -
//  m_axis   | out | character[5:0], 2'b0 pad      | -     | last char of number
//
// Output: one character beat per cycle on m_axis while m_axis tready is high;
//   a number takes 1 to DIGIT_PLACES+1 beats (sign plus significant digits),
//   paced by the serializer's output port. An input beat passes the front
//   stage, digit cell and serializer registers before its first character.
// The chain holds up to DIGIT_PLACES+1 numbers in flight while the
//   serializer drains; s_axis keeps accepting until the chain fills.
// Reset (i_rst_n low, synchronous) empties every stage; nothing else to clear.
// Stalls on m_axis back up the chain stage by stage to s_axis tready.
`default_nettype none

module signed_int_to_decimal_ascii_core #(
    parameter int DIGIT_PLACES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [27:0] number
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [5:0] character
    output logic             o_m_axis_tlast    // last_char
);
    import sidtoa_pkg::*;

    localparam int          DIG_BITS = DIGIT_PLACES * DIGIT_W;
    localparam int          WORD_W   = MAG_W + DIG_BITS + 1;
    localparam logic [63:0] LIMIT    = pow10(DIGIT_PLACES) - 64'd1;

    // ---------------- front stage: magnitude, sign, saturation -------------
    logic [NUMBER_W-1:0] raw;
    logic                neg;
    logic [MAG_W-1:0]    mag_abs;
    logic [MAG_W-1:0]    mag_sat;
    logic                r_front_valid;
    logic                r_front_sign;
    logic [MAG_W-1:0]    r_front_mag;
    logic                front_ready;

    assign raw     = i_s_axis_tdata[NUMBER_W-1:0];
    assign neg     = raw[NUMBER_W-1];
    // the most negative pattern negates to 2**27, which fits unsigned
    assign mag_abs = neg ? MAG_W'(~raw + NUMBER_W'(1)) : MAG_W'(raw);
    assign mag_sat = ({{(64-MAG_W){1'b0}}, mag_abs} > LIMIT) ? MAG_W'(LIMIT) : mag_abs;

    assign o_s_axis_tready = !r_front_valid || front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_front_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_front_sign <= neg;
            r_front_mag  <= mag_sat;
        end
    end

    // ---------------- digit chain, most significant place first ------------
    logic [DIGIT_PLACES:0]  chain_valid;
    logic [DIGIT_PLACES:0]  chain_ready;
    logic [WORD_W-1:0]      chain_word [DIGIT_PLACES+1];

    assign chain_valid[0] = r_front_valid;
    assign chain_word[0]  = {{DIG_BITS{1'b0}}, r_front_sign, r_front_mag};
    assign front_ready    = chain_ready[0];

    for (genvar k = 0; k < DIGIT_PLACES; k++) begin : g_cell
        sidtoa_digit_cell #(
            .DIGIT_PLACES (DIGIT_PLACES),
            .PLACE        (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_word  (chain_word[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_word  (chain_word[k+1])
        );
    end

    // ---------------- serializer ------------------------------------------
    t_char ser_char;

    sidtoa_serializer #(
        .DIGIT_PLACES (DIGIT_PLACES)
    ) u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[DIGIT_PLACES]),
        .o_ready  (chain_ready[DIGIT_PLACES]),
        .i_sign   (chain_word[DIGIT_PLACES][MAG_W]),
        .i_digits (chain_word[DIGIT_PLACES][WORD_W-1:MAG_W+1]),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_char   (ser_char),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, ser_char};

    // ---------------- checks ----------------------------------------------
    // a minus sign is never the closing character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (ser_char == CHAR_MINUS) |-> !o_m_axis_tlast)
        else $error("minus sign marked last");

    // only '-' or a decimal digit leaves the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (ser_char == CHAR_MINUS) ||
            ((ser_char >= CHAR_ZERO) && (ser_char <= CHAR_ZERO + t_char'(9))))
        else $error("illegal character");

    // a beat after the minus sign is always a nonzero leading digit
    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && (ser_char == CHAR_MINUS) |=>
            o_m_axis_tvalid && (ser_char != CHAR_ZERO) && (ser_char != CHAR_MINUS))
        else $error("minus not followed by leading digit");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

>>> bench/sidtoa_text_checker.sv
// Checker for the signed integer to decimal ASCII core: watches both streams,
// predicts each number's character run and compares beat by beat.
// Depends on sidtoa_pkg.
module sidtoa_text_checker #(
    parameter int DIGIT_PLACES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [27:0] number
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,   // [5:0] character
    input  wire logic        i_m_tlast,   // last_char
    output int               o_chars_pending,
    output int               o_mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import sidtoa_pkg::*;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_char;

    t_text_char expected_chars[$];
    int         mismatch_count = 0;
    int         beat_index     = 0;

    assign o_mismatch_count = mismatch_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %0t beat %0d: %s got %0d expected %0d",
                 $time, beat_index, what, got, want);
        mismatch_count++;
    endtask

    // Decimal text of one number: optional sign, then significant digits,
    // magnitude clamped to DIGIT_PLACES nines.
    function automatic void expand_number_text(input logic [NUMBER_W-1:0] num);
        logic              neg;
        logic [MAG_W-1:0]  mag_bits;
        longint unsigned   mag;
        longint unsigned   weight;
        longint unsigned   digit;
        bit                started;
        t_text_char        text[$];
        neg      = num[NUMBER_W-1];
        mag_bits = neg ? (~num + 1'b1) : num;
        mag      = longint'(mag_bits);
        weight   = 1;
        started  = 1'b0;
        for (int i = 1; i < DIGIT_PLACES; i++) weight *= 10;
        if (mag > weight * 10 - 1) mag = weight * 10 - 1;
        if (mag == 0) begin
            text.push_back('{ch: CHAR_ZERO, last: 1'b0});
        end else begin
            if (neg) text.push_back('{ch: CHAR_MINUS, last: 1'b0});
            for (int i = 0; i < DIGIT_PLACES; i++) begin
                digit  = (mag / weight) % 10;
                weight = weight / 10;
                if (digit != 0) started = 1'b1;
                if (started) text.push_back('{ch: t_char'(CHAR_ZERO + digit), last: 1'b0});
            end
        end
        text[text.size()-1].last = 1'b1;
        foreach (text[i]) expected_chars.push_back(text[i]);
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) expand_number_text(i_s_tdata[NUMBER_W-1:0]);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character", int'(i_m_tdata), -1);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_m_tdata[CHAR_W-1:0] != want.ch)
                        report_mismatch("character", int'(i_m_tdata[CHAR_W-1:0]),
                                        int'(want.ch));
                    if (i_m_tlast != want.last)
                        report_mismatch("tlast", int'(i_m_tlast), int'(want.last));
                    if (i_m_tdata[7:CHAR_W] != '0)
                        report_mismatch("tdata pad", int'(i_m_tdata[7:CHAR_W]), 0);
                end
                beat_index++;
            end
            o_chars_pending <= expected_chars.size();
        end
    end

endmodule

>>> bench/tb.sv
// Testbench top for signed_int_to_decimal_ascii_core: clock, reset, number
// stimulus with random idling and output stalls, and the final verdict.
// Depends on sidtoa_pkg, the core and sidtoa_text_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sidtoa_pkg::*;

    localparam int DIGIT_PLACES = 8;
    localparam int RANDOM_ITEMS = 440;
    localparam int N_CORNERS    = 22;

    // edge numbers: zero, single digits, place boundaries, range limits,
    // saturation just past the limits and the most negative 28-bit pattern
    localparam int CORNERS [N_CORNERS] = '{
        0, 1, -1, 9, 10, -10, 100, -7, 10000000, -10000000,
        12345678, -87654321, 1000005, 90000000, 99999999, -99999999,
        100000000, -100000000, 134217727, -134217728, 55555555, -40302010
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [31:0] i_s_axis_tdata = '0;    // [27:0] number, [31:28] zero pad
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;         // [5:0] character, [7:6] pad
    logic        o_m_axis_tlast;         // last_char
    int          chars_pending;
    int          mismatch_count;
    int          ready_stall = 0;
    int          ready_cycle = 0;

    signed_int_to_decimal_ascii_core #(.DIGIT_PLACES(DIGIT_PLACES)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    sidtoa_text_checker #(.DIGIT_PLACES(DIGIT_PLACES)) text_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_axis_tvalid),
        .i_s_tready       (o_s_axis_tready),
        .i_s_tdata        (i_s_axis_tdata),
        .i_m_tvalid       (o_m_axis_tvalid),
        .i_m_tready       (i_m_axis_tready),
        .i_m_tdata        (o_m_axis_tdata),
        .i_m_tlast        (o_m_axis_tlast),
        .o_chars_pending  (chars_pending),
        .o_mismatch_count (mismatch_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Numbers of random length and sign; a share of raw 28-bit patterns and
    // values around the saturation limit.
    function automatic int random_number();
        int roll;
        int places;
        int hi;
        int mag;
        roll = $urandom_range(0, 19);
        if (roll == 0) return int'($urandom);
        mag = 0;
        if (roll == 1) begin
            mag = $urandom_range(99999990, 100000010);
        end else begin
            places = $urandom_range(1, DIGIT_PLACES);
            hi = 1;
            repeat (places) hi = hi * 10;
            mag = $urandom_range(0, hi - 1);
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Output stalls; no new stall starts while bit 9 of ready_cycle is set.
    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if (ready_cycle[9]) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            ready_stall <= pick_gap();
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send_number(input int value, input bit no_gap);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, value[NUMBER_W-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;   // junk while idle
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every predicted character has come out.
    task automatic drain_text();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chars_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNERS[i]) send_number(CORNERS[i], 1'b0);
        drain_text();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_number(random_number(), (n % 64) < 16);
            if (n == RANDOM_ITEMS / 2) drain_text();
        end
        drain_text();

        // latency of the core plus margin for any stray beat
        repeat (DIGIT_PLACES + 12) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
